// ----- hw/rtl/kte_pkg.sv -----
// Package for the two-kernel 3x3 Kirsch edge block.
// Holds widths, reset values, register codes and the transfer structs.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package kte_pkg;

  localparam int MaxLine  = 1024;
  localparam int IdxW     = $clog2(MaxLine);
  localparam int LenW     = 11;
  localparam int RcntW    = 16;
  localparam int RowW     = RcntW + 1;
  localparam int PixW     = 8;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;
  localparam int SumW     = 14;

  localparam logic [LenW-1:0]  LineLenReset = LenW'(640);
  localparam logic [RcntW-1:0] RowCntReset  = RcntW'(480);
  localparam logic [LenW-1:0]  LenMin       = LenW'(3);
  localparam logic [LenW-1:0]  LenMax       = LenW'(MaxLine);
  localparam logic [RcntW-1:0] RowMin       = RcntW'(3);
  localparam logic [SumW-1:0]  EdgeMax      = SumW'(255);

  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef enum logic {
    RegLineLength = 1'b0,
    RegRowCount   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic            opcode;
    logic [PixW-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] edge_out;
    logic            frame_last;
  } out_item_t;

  typedef struct packed {
    logic [LenW-1:0]  line_length;
    logic [RcntW-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic            emit;
    logic            last;
    logic [2:0]      row_ok;
    logic [2:0]      col_ok;
    logic [IdxW-1:0] idx;
  } pos_info_t;

endpackage

// ----- hw/rtl/kte_regs.sv -----
// Configuration registers of the edge block behind an APB-style port.
// Holds line length and row count; uses kte_pkg.
module kte_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kte_pkg::AddrW-1:0] paddr,
  input  logic [kte_pkg::DataW-1:0] pwdata,
  output logic [kte_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output kte_pkg::cfg_t             cfg_o
);

  logic [kte_pkg::LenW-1:0]  line_length_q;
  logic [kte_pkg::RcntW-1:0] row_count_q;
  logic                      wr_en;
  kte_pkg::reg_idx_e         sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = kte_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= kte_pkg::LineLenReset;
      row_count_q   <= kte_pkg::RowCntReset;
    end else if (wr_en) begin
      case (sel)
        kte_pkg::RegLineLength: line_length_q <= pwdata[kte_pkg::LenW-1:0];
        kte_pkg::RegRowCount:   row_count_q   <= pwdata[kte_pkg::RcntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      kte_pkg::RegLineLength: prdata = kte_pkg::DataW'(line_length_q);
      kte_pkg::RegRowCount:   prdata = kte_pkg::DataW'(row_count_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.line_length = line_length_q;
  assign cfg_o.row_count   = row_count_q;

endmodule

// ----- hw/rtl/kte_pos.sv -----
// Frame position tracking for the edge block: column and row of the next item.
// Works out emission, frame end, border masks and line store index; uses kte_pkg.
module kte_pos (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kte_pkg::cfg_t        cfg_i,
  input  logic                 step_i,
  output kte_pkg::pos_info_t   info_o
);

  localparam int LenW = kte_pkg::LenW;
  localparam int RowW = kte_pkg::RowW;
  localparam int IdxW = kte_pkg::IdxW;

  logic [IdxW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [LenW-1:0]  w_eff;
  logic [kte_pkg::RcntW-1:0] h_eff;
  logic [LenW-1:0]  col_ext, col_inc, oj;
  logic [RowW-1:0]  oi;
  logic             emit, last;
  logic [2:0]       row_ok, col_ok;

  always_comb begin
    if (cfg_i.line_length < kte_pkg::LenMin) begin
      w_eff = kte_pkg::LenMin;
    end else if (cfg_i.line_length > kte_pkg::LenMax) begin
      w_eff = kte_pkg::LenMax;
    end else begin
      w_eff = cfg_i.line_length;
    end
    h_eff = (cfg_i.row_count < kte_pkg::RowMin) ? kte_pkg::RowMin : cfg_i.row_count;

    col_ext = LenW'(col_q);
    col_inc = col_ext + LenW'(1);
    emit    = (row_q > RowW'(2)) || ((row_q == RowW'(2)) && (col_ext >= LenW'(2)));

    if (col_ext >= LenW'(2)) begin
      oi = row_q - RowW'(2);
      oj = col_ext - LenW'(2);
    end else begin
      oi = row_q - RowW'(3);
      oj = col_ext + w_eff - LenW'(2);
    end

    for (int r = 0; r < 3; r++) begin
      row_ok[r] = ((RowW+1)'(oi) + (RowW+1)'(r)) < (RowW+1)'(h_eff);
      col_ok[r] = ((LenW+1)'(oj) + (LenW+1)'(r)) < (LenW+1)'(w_eff);
    end

    last = emit && (oi == RowW'(h_eff) - RowW'(1)) && (oj == w_eff - LenW'(1));

    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end else begin
      col_d = col_inc[IdxW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign info_o.emit   = emit;
  assign info_o.last   = last;
  assign info_o.row_ok = row_ok;
  assign info_o.col_ok = col_ok;
  assign info_o.idx    = col_q;

endmodule

// ----- hw/rtl/kte_lines.sv -----
// Two line delays of the edge block, each a 1024 x 8 memory with registered read.
// The first holds the previous row, the second the row before it; uses kte_pkg.
module kte_lines (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [kte_pkg::IdxW-1:0]   rd_idx_i,
  input  logic                       wr_en_i,
  input  logic [kte_pkg::IdxW-1:0]   wr_idx_i,
  input  logic [kte_pkg::PixW-1:0]   wr_pix_i,
  output logic [kte_pkg::PixW-1:0]   one_line_o,
  output logic [kte_pkg::PixW-1:0]   two_lines_o
);

  logic [kte_pkg::PixW-1:0] line1_mem [kte_pkg::MaxLine];
  logic [kte_pkg::PixW-1:0] line2_mem [kte_pkg::MaxLine];
  logic [kte_pkg::PixW-1:0] one_line_q;
  logic [kte_pkg::PixW-1:0] two_lines_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      one_line_q  <= line1_mem[rd_idx_i];
      two_lines_q <= line2_mem[rd_idx_i];
    end
    if (wr_en_i) begin
      line1_mem[wr_idx_i] <= wr_pix_i;
      line2_mem[wr_idx_i] <= one_line_q;
    end
  end

  assign one_line_o  = one_line_q;
  assign two_lines_o = two_lines_q;

endmodule

// ----- hw/rtl/kte_window.sv -----
// 3x3 window registers and the north plus west Kirsch kernel sum.
// Taps outside the image are masked to zero; uses kte_pkg.
module kte_window (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic [kte_pkg::PixW-1:0]  top_i,
  input  logic [kte_pkg::PixW-1:0]  mid_i,
  input  logic [kte_pkg::PixW-1:0]  bot_i,
  input  logic [2:0]                row_ok_i,
  input  logic [2:0]                col_ok_i,
  output logic [kte_pkg::PixW-1:0]  edge_o
);

  localparam int SumW = kte_pkg::SumW;

  logic [2:0][2:0][kte_pkg::PixW-1:0] win_q, win_d, tap;
  logic [SumW-1:0] n_pos, n_neg, w_pos, w_neg, n_abs, w_abs, total;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = top_i;
    win_d[1][2] = mid_i;
    win_d[2][2] = bot_i;

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap[r][c] = (row_ok_i[r] && col_ok_i[c]) ? win_d[r][c] : '0;
      end
    end

    n_pos = SumW'(tap[0][0]) + SumW'(tap[0][1]) + SumW'(tap[0][2]);
    n_neg = SumW'(tap[1][0]) + SumW'(tap[1][2]) + SumW'(tap[2][0])
          + SumW'(tap[2][1]) + SumW'(tap[2][2]);
    w_pos = SumW'(tap[0][0]) + SumW'(tap[1][0]) + SumW'(tap[2][0]);
    w_neg = SumW'(tap[0][1]) + SumW'(tap[0][2]) + SumW'(tap[1][2])
          + SumW'(tap[2][1]) + SumW'(tap[2][2]);

    n_pos = (n_pos << 2) + n_pos;
    w_pos = (w_pos << 2) + w_pos;
    n_neg = (n_neg << 1) + n_neg;
    w_neg = (w_neg << 1) + w_neg;

    n_abs = (n_pos >= n_neg) ? (n_pos - n_neg) : (n_neg - n_pos);
    w_abs = (w_pos >= w_neg) ? (w_pos - w_neg) : (w_neg - w_pos);
    total = n_abs + w_abs;
    edge_o = (total > kte_pkg::EdgeMax) ? kte_pkg::EdgeMax[kte_pkg::PixW-1:0]
                                        : total[kte_pkg::PixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

endmodule

// ----- hw/rtl/kirsch_two_kernel_edge_3x3.sv -----
// Top level of the two-kernel 3x3 Kirsch edge block.
// Instantiates kte_regs, kte_pos, kte_lines and kte_window; uses kte_pkg.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o  kte_pkg::in_item_t
//   out       output     out_valid_o / out_stall_i kte_pkg::out_item_t
//   config    input      APB write / read         line_length, row_count
//
// One item is taken per clock while in_stall_o is low; the item is registered in
// the s1 stage, and its result is then registered in the output register.
// The rate is set by the single read and write port of each line memory.
// Reset clears position, window and valid flags; line memories are not cleared.
// A stalled output holds its result; one more emitting item may wait in s1.
module kirsch_two_kernel_edge_3x3 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  kte_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output kte_pkg::out_item_t        out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kte_pkg::AddrW-1:0] paddr,
  input  logic [kte_pkg::DataW-1:0] pwdata,
  output logic [kte_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  kte_pkg::cfg_t               cfg;
  kte_pkg::pos_info_t          info;
  kte_pkg::pos_info_t          s1_info_q;
  logic                        s1_valid_q;
  logic [kte_pkg::PixW-1:0]    s1_pix_q;
  logic [kte_pkg::PixW-1:0]    one_line, two_lines, edge_val;
  logic                        out_valid_q;
  kte_pkg::out_item_t          out_data_q;
  logic                        out_ready, s1_fire, in_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_info_q.emit || out_ready);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  kte_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kte_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_fire),
    .info_o (info)
  );

  kte_lines u_lines (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .rd_idx_i    (info.idx),
    .wr_en_i     (s1_fire),
    .wr_idx_i    (s1_info_q.idx),
    .wr_pix_i    (s1_pix_q),
    .one_line_o  (one_line),
    .two_lines_o (two_lines)
  );

  kte_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_fire),
    .top_i    (two_lines),
    .mid_i    (one_line),
    .bot_i    (s1_pix_q),
    .row_ok_i (s1_info_q.row_ok),
    .col_ok_i (s1_info_q.col_ok),
    .edge_o   (edge_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_info_q <= info;
      s1_pix_q  <= (in_data_i.opcode == kte_pkg::OpFlush) ? '0 : in_data_i.pixel_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_info_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_info_q.emit) begin
      out_data_q.edge_out   <= edge_val;
      out_data_q.frame_last <= s1_info_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |-> !in_fire)
    else $error("Item accepted while the window stage was held.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_info_q.emit) |=> out_valid_q)
    else $error("Emitting item did not load the result register.");

  a_result_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !(s1_fire && s1_info_q.emit)) |=> !out_valid_q)
    else $error("Result was repeated after its transfer.");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_info_q.emit && out_valid_q && out_stall_i) |-> !s1_fire)
    else $error("Window stage overwrote a stalled result.");

endmodule
